[rtl/qrr_pkg.sv]
// Shared types and constants for the quadratic real-roots pipeline.
`timescale 1ns / 1ps

package qrr_pkg;

    // Result format: signed Q16.16.
    localparam int OUT_W    = 32;
    localparam int OUT_FRAC = 16;

    // Extra fraction bits put under the discriminant before the square root.
    localparam int SQ_SHIFT = 2 * OUT_FRAC;

    // Width used for the saturation compare of a quotient.
    localparam int CMP_W = 64;

    typedef struct packed {
        logic negd;
        logic degen;
    } t_flags;

endpackage

[rtl/qrr_if.sv]
// Valid/ready channel interfaces for coefficient beats and root beats.
`timescale 1ns / 1ps

interface qrr_in_if #(parameter int COEF_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;

    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrr_out_if;
    import qrr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] root_low;
    logic signed [OUT_W-1:0] root_high;
    logic                    no_real_roots;
    logic                    degenerate;
    logic                    saturated;

    modport source (output valid, root_low, root_high, no_real_roots, degenerate, saturated,
                    input ready);
    modport sink   (input valid, root_low, root_high, no_real_roots, degenerate, saturated,
                    output ready);
endinterface

[rtl/qrr_disc.sv]
// Two-stage exact discriminant b*b - 4*a*c with negative and zero-a flags.
`timescale 1ns / 1ps

module qrr_disc #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COEF_WIDTH-1:0] i_a,
    input  logic signed [COEF_WIDTH-1:0] i_b,
    input  logic signed [COEF_WIDTH-1:0] i_c,
    output logic                         o_valid,
    output logic [2*COEF_WIDTH+1:0]      o_disc,
    output qrr_pkg::t_flags              o_flags,
    output logic signed [COEF_WIDTH-1:0] o_a,
    output logic signed [COEF_WIDTH-1:0] o_b
);
    import qrr_pkg::*;

    localparam int W  = COEF_WIDTH;
    localparam int PW = 2 * W;
    localparam int DW = 2 * W + 2;

    logic signed [PW-1:0] n_bb;
    logic signed [PW-1:0] n_ac;
    logic signed [PW-1:0] r_bb;
    logic signed [PW-1:0] r_ac;
    logic signed [W-1:0]  r_a1;
    logic signed [W-1:0]  r_b1;
    logic                 r_vld1;

    logic signed [DW:0]   n_d;
    t_flags               n_flags;
    logic [DW-1:0]        r_d;
    t_flags               r_flags;
    logic signed [W-1:0]  r_a2;
    logic signed [W-1:0]  r_b2;
    logic                 r_vld2;

    assign n_bb = i_b * i_b;
    assign n_ac = i_a * i_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bb <= n_bb;
            r_ac <= n_ac;
            r_a1 <= i_a;
            r_b1 <= i_b;
        end
    end

    assign n_d           = (DW+1)'(r_bb) - ((DW+1)'(r_ac) <<< 2);
    assign n_flags.negd  = n_d[DW];
    assign n_flags.degen = (r_a1 == '0);

    // A flagged item feeds zero downstream; its roots are discarded anyway.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d     <= (n_flags.negd || n_flags.degen) ? '0 : n_d[DW-1:0];
            r_flags <= n_flags;
            r_a2    <= r_a1;
            r_b2    <= r_b1;
        end
    end

    assign o_valid = r_vld2;
    assign o_disc  = r_d;
    assign o_flags = r_flags;
    assign o_a     = r_a2;
    assign o_b     = r_b2;

endmodule

[rtl/qrr_sqrt.sv]
// Pipelined integer square root, one result bit resolved per stage.
`timescale 1ns / 1ps

module qrr_sqrt #(
    parameter int IN_W  = 66,
    parameter int TAG_W = 34
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [IN_W-1:0]     i_rad,
    input  logic [TAG_W-1:0]    i_tag,
    output logic                o_valid,
    output logic [IN_W/2-1:0]   o_root,
    output logic [TAG_W-1:0]    o_tag
);
    localparam int SW = IN_W / 2;
    localparam int RW = SW + 3;

    logic [SW-1:0]    r_vld;
    logic [SW-1:0]    r_root [0:SW-1];
    logic [TAG_W-1:0] r_tag  [0:SW-1];
    logic [IN_W-1:0]  r_x    [0:SW-2];
    logic [RW-1:0]    r_rem  [0:SW-2];

    for (genvar gk = 0; gk < SW; gk++) begin : g_stage
        logic [IN_W-1:0]  s_x;
        logic [RW-1:0]    s_rem;
        logic [SW-1:0]    s_root;
        logic [TAG_W-1:0] s_tag;
        logic             s_vld;
        logic [RW-1:0]    s_pre;
        logic [RW-1:0]    s_trial;
        logic             s_fit;

        if (gk == 0) begin : g_first
            assign s_x    = i_rad;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_tag  = i_tag;
            assign s_vld  = i_valid;
        end else begin : g_next
            assign s_x    = r_x[gk-1];
            assign s_rem  = r_rem[gk-1];
            assign s_root = r_root[gk-1];
            assign s_tag  = r_tag[gk-1];
            assign s_vld  = r_vld[gk-1];
        end

        // Bring down the next two radicand bits and try the bit (4*root + 1).
        assign s_pre   = {s_rem[RW-3:0], s_x[IN_W-1 -: 2]};
        assign s_trial = {1'b0, s_root, 2'b01};
        assign s_fit   = (s_pre >= s_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gk] <= 1'b0;
            end else if (i_en) begin
                r_vld[gk] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[gk] <= {s_root[SW-2:0], s_fit};
                r_tag[gk]  <= s_tag;
            end
        end

        if (gk < SW - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[gk]   <= s_x << 2;
                    r_rem[gk] <= s_fit ? (s_pre - s_trial) : s_pre;
                end
            end
        end
    end

    assign o_valid = r_vld[SW-1];
    assign o_root  = r_root[SW-1];
    assign o_tag   = r_tag[SW-1];

endmodule

[rtl/qrr_div.sv]
// Two-lane pipelined divider: root numerators over 2a, rounded and clamped to Q16.16.
`timescale 1ns / 1ps

module qrr_div #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [COEF_WIDTH+16:0]        i_root,
    input  logic signed [COEF_WIDTH-1:0]  i_a,
    input  logic signed [COEF_WIDTH-1:0]  i_b,
    input  qrr_pkg::t_flags               i_flags,
    output logic                          o_valid,
    output logic signed [qrr_pkg::OUT_W-1:0] o_res [0:1],
    output logic                          o_sat,
    output qrr_pkg::t_flags               o_flags
);
    import qrr_pkg::*;

    localparam int W   = COEF_WIDTH;
    localparam int SW  = W + 17;          // square root width
    localparam int NW  = W + 19;          // signed numerator width
    localparam int NMW = W + 18;          // numerator magnitude width
    localparam int MW  = W + 20;          // dividend width, also quotient width
    localparam int DVW = W + 1;           // |2a|
    localparam int VW  = W + 2;           // divisor 4|a|
    localparam int RW  = VW + 1;
    localparam logic [CMP_W-1:0] LIM_POS = (CMP_W'(1) << (OUT_W - 1)) - CMP_W'(1);
    localparam logic [CMP_W-1:0] LIM_NEG = CMP_W'(1) << (OUT_W - 1);

    // Operand setup: q = floor((2|N| + |2a|) / (4|a|)) rounds |N| / |2a| half away.
    logic signed [NW-1:0] n_base;
    logic signed [NW-1:0] n_sx;
    logic signed [NW-1:0] n_num [0:1];
    logic [NW-1:0]        n_mag [0:1];
    logic [W-1:0]         n_amag;
    logic [DVW-1:0]       n_den;

    logic                 r_pvld;
    logic [MW-1:0]        r_pm [0:1];
    logic [VW-1:0]        r_pv;
    logic [1:0]           r_pneg;
    t_flags               r_pflags;

    assign n_base = -(NW'(i_b) <<< OUT_FRAC);
    assign n_sx   = NW'(i_root);
    assign n_num[0] = n_base - n_sx;
    assign n_num[1] = n_base + n_sx;
    assign n_amag = i_a[W-1] ? (~i_a + W'(1)) : i_a;
    assign n_den  = {n_amag, 1'b0};

    for (genvar gl = 0; gl < 2; gl++) begin : g_mag
        assign n_mag[gl] = n_num[gl][NW-1] ? -n_num[gl] : n_num[gl];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else if (i_en) begin
            r_pvld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pm[0]   <= MW'({n_mag[0][NMW-1:0], 1'b0}) + MW'(n_den);
            r_pm[1]   <= MW'({n_mag[1][NMW-1:0], 1'b0}) + MW'(n_den);
            r_pv      <= {n_den, 1'b0};
            r_pneg[0] <= n_num[0][NW-1] ^ i_a[W-1];
            r_pneg[1] <= n_num[1][NW-1] ^ i_a[W-1];
            r_pflags  <= i_flags;
        end
    end

    // Restoring division, one quotient bit per stage for both lanes.
    logic [MW-1:0]  r_vld;
    logic [MW-1:0]  r_q   [0:MW-1][0:1];
    logic [1:0]     r_neg [0:MW-1];
    t_flags         r_flags [0:MW-1];
    logic [MW-1:0]  r_m   [0:MW-2][0:1];
    logic [RW-1:0]  r_rem [0:MW-2][0:1];
    logic [VW-1:0]  r_v   [0:MW-2];

    for (genvar gj = 0; gj < MW; gj++) begin : g_stage
        logic [MW-1:0] s_m   [0:1];
        logic [MW-1:0] s_q   [0:1];
        logic [RW-1:0] s_rem [0:1];
        logic [VW-1:0] s_v;
        logic [1:0]    s_neg;
        t_flags        s_flags;
        logic          s_vld;

        if (gj == 0) begin : g_first
            assign s_m[0]   = r_pm[0];
            assign s_m[1]   = r_pm[1];
            assign s_q[0]   = '0;
            assign s_q[1]   = '0;
            assign s_rem[0] = '0;
            assign s_rem[1] = '0;
            assign s_v      = r_pv;
            assign s_neg    = r_pneg;
            assign s_flags  = r_pflags;
            assign s_vld    = r_pvld;
        end else begin : g_next
            assign s_m[0]   = r_m[gj-1][0];
            assign s_m[1]   = r_m[gj-1][1];
            assign s_q[0]   = r_q[gj-1][0];
            assign s_q[1]   = r_q[gj-1][1];
            assign s_rem[0] = r_rem[gj-1][0];
            assign s_rem[1] = r_rem[gj-1][1];
            assign s_v      = r_v[gj-1];
            assign s_neg    = r_neg[gj-1];
            assign s_flags  = r_flags[gj-1];
            assign s_vld    = r_vld[gj-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gj] <= 1'b0;
            end else if (i_en) begin
                r_vld[gj] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[gj]   <= s_neg;
                r_flags[gj] <= s_flags;
            end
        end

        if (gj < MW - 1) begin : g_keep_v
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v[gj] <= s_v;
                end
            end
        end

        for (genvar gl = 0; gl < 2; gl++) begin : g_lane
            logic [RW-1:0] s_pre;
            logic          s_fit;

            assign s_pre = {s_rem[gl][RW-2:0], s_m[gl][MW-1]};
            assign s_fit = (s_pre >= {1'b0, s_v});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q[gj][gl] <= {s_q[gl][MW-2:0], s_fit};
                end
            end

            if (gj < MW - 1) begin : g_keep
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_m[gj][gl]   <= s_m[gl] << 1;
                        r_rem[gj][gl] <= s_fit ? (s_pre - {1'b0, s_v}) : s_pre;
                    end
                end
            end
        end
    end

    // Sign and clamp stage.
    logic                    n_lsat [0:1];
    logic signed [OUT_W-1:0] n_res  [0:1];
    logic                    r_ovld;
    logic signed [OUT_W-1:0] r_res  [0:1];
    logic                    r_sat;
    t_flags                  r_oflags;

    for (genvar gl = 0; gl < 2; gl++) begin : g_clamp
        logic [CMP_W-1:0] s_qx;

        assign s_qx = CMP_W'(r_q[MW-1][gl]);

        always_comb begin
            if (r_neg[MW-1][gl]) begin
                n_lsat[gl] = (s_qx > LIM_NEG);
                n_res[gl]  = n_lsat[gl] ? LIM_NEG[OUT_W-1:0] : -s_qx[OUT_W-1:0];
            end else begin
                n_lsat[gl] = (s_qx > LIM_POS);
                n_res[gl]  = n_lsat[gl] ? LIM_POS[OUT_W-1:0] : s_qx[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_ovld <= r_vld[MW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res[0] <= n_res[0];
            r_res[1] <= n_res[1];
            r_sat    <= n_lsat[0] || n_lsat[1];
            r_oflags <= r_flags[MW-1];
        end
    end

    assign o_valid  = r_ovld;
    assign o_res[0] = r_res[0];
    assign o_res[1] = r_res[1];
    assign o_sat    = r_sat;
    assign o_flags  = r_oflags;

endmodule

[rtl/quadratic_real_roots_unit.sv]
// Top level of the quadratic real-roots pipeline with its output register.
`timescale 1ns / 1ps

// Takes one coefficient beat (a, b, c of a*x^2 + b*x + c, signed fixed point) per
// cycle and returns one root beat per coefficient beat, in order: both real roots as
// signed Q16.16, smaller first, rounded to nearest with ties away from zero and
// clamped to the 32-bit range (saturated set when a root was clamped). A negative
// discriminant sets no_real_roots and a zero a sets degenerate; both give zero roots.
// The fraction position of the coefficients cancels and does not matter. A beat
// passes in order through the discriminant stages, a square root of COEF_WIDTH + 17
// bits, operand setup, a division with COEF_WIDTH + 20 quotient bits, clamping and
// the output register. A new beat is taken in every cycle except while the whole
// pipeline holds, which it does only while a result waits at the output and the
// sink is not ready.
module quadratic_real_roots_unit #(
    parameter int COEF_WIDTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    qrr_in_if.sink       i_coef,
    qrr_out_if.source    o_root
);
    import qrr_pkg::*;

    localparam int W     = COEF_WIDTH;
    localparam int DW    = 2 * W + 2;
    localparam int IN_W  = DW + SQ_SHIFT;
    localparam int SW    = IN_W / 2;
    localparam int TAG_W = $bits(t_flags) + 2 * W;

    logic r_out_vld;
    logic n_en;

    assign n_en         = !r_out_vld || o_root.ready;
    assign i_coef.ready = n_en;

    // Discriminant.
    logic                d_vld;
    logic [DW-1:0]       d_disc;
    t_flags              d_flags;
    logic signed [W-1:0] d_a;
    logic signed [W-1:0] d_b;

    qrr_disc #(.COEF_WIDTH(W)) u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (i_coef.valid),
        .i_a     (i_coef.coef_a),
        .i_b     (i_coef.coef_b),
        .i_c     (i_coef.coef_c),
        .o_valid (d_vld),
        .o_disc  (d_disc),
        .o_flags (d_flags),
        .o_a     (d_a),
        .o_b     (d_b)
    );

    // Square root of D with 16 fraction bits.
    logic             s_vld;
    logic [SW-1:0]    s_root;
    logic [TAG_W-1:0] s_tag;
    t_flags           s_flags;
    logic [W-1:0]     s_a;
    logic [W-1:0]     s_b;

    qrr_sqrt #(.IN_W(IN_W), .TAG_W(TAG_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (d_vld),
        .i_rad   ({d_disc, {SQ_SHIFT{1'b0}}}),
        .i_tag   ({d_flags, d_a, d_b}),
        .o_valid (s_vld),
        .o_root  (s_root),
        .o_tag   (s_tag)
    );

    assign {s_flags, s_a, s_b} = s_tag;

    // Both roots.
    logic                    q_vld;
    logic signed [OUT_W-1:0] q_res [0:1];
    logic                    q_sat;
    t_flags                  q_flags;

    qrr_div #(.COEF_WIDTH(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (s_vld),
        .i_root  (s_root),
        .i_a     (s_a),
        .i_b     (s_b),
        .i_flags (s_flags),
        .o_valid (q_vld),
        .o_res   (q_res),
        .o_sat   (q_sat),
        .o_flags (q_flags)
    );

    // Ordering and flag masking into the output register.
    logic                    n_void;
    logic                    n_swap;
    logic signed [OUT_W-1:0] r_low;
    logic signed [OUT_W-1:0] r_high;
    logic                    r_negd;
    logic                    r_degen;
    logic                    r_sat;

    assign n_void = q_flags.negd || q_flags.degen;
    assign n_swap = (q_res[0] > q_res[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (n_en) begin
            r_out_vld <= q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_low   <= n_void ? '0 : (n_swap ? q_res[1] : q_res[0]);
            r_high  <= n_void ? '0 : (n_swap ? q_res[0] : q_res[1]);
            r_negd  <= q_flags.negd && !q_flags.degen;
            r_degen <= q_flags.degen;
            r_sat   <= q_sat && !n_void;
        end
    end

    assign o_root.valid         = r_out_vld;
    assign o_root.root_low      = r_low;
    assign o_root.root_high     = r_high;
    assign o_root.no_real_roots = r_negd;
    assign o_root.degenerate    = r_degen;
    assign o_root.saturated     = r_sat;

`ifndef SYNTHESIS
    a_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_root.valid |-> (o_root.root_low <= o_root.root_high))
        else $error("root_low above root_high");

    a_void : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_root.valid && (o_root.degenerate || o_root.no_real_roots) |->
        (o_root.root_low == '0) && (o_root.root_high == '0) && !o_root.saturated)
        else $error("flagged beat carries roots or saturation");

    a_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_root.valid |-> !(o_root.degenerate && o_root.no_real_roots))
        else $error("degenerate and no_real_roots both set");

    a_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_root.valid |-> i_coef.ready)
        else $error("input stalled with empty output register");
`endif

endmodule
